// ----- sv/rpbm_pkg.sv -----
package rpbm_pkg;

  // Default geometry of the block.
  localparam int RPBM_MEM_BYTES   = 65536;
  localparam int RPBM_MAX_REGIONS = 8;

  // Widths of the stream words.
  localparam int CMD_W      = 3;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 32;

  // Command codes carried in the slave-side tuser.
  localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STORE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MAP   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UNMAP = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // capture the input word
    logic chk;       // register the bounds, region and map checks
    logic tbl_upd;   // apply a map, unmap or clear to the region table
    logic cnt_clr;   // zero the byte counter
    logic cnt_inc;   // step the byte counter
    logic mem_we;    // write the current store byte
    logic rd_cap;    // capture the byte read in the previous cycle
    logic wipe;      // write zero at the wipe counter
    logic res_load;  // load the result into the output register
  } rpbm_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             allowed;
    logic             last_byte;
    logic             wipe_last;
    logic             res_free;
  } rpbm_sts_t;

endpackage

// ----- sv/rpbm_ram.sv -----
module rpbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- sv/rpbm_controller.sv -----
module rpbm_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  rpbm_pkg::rpbm_sts_t sts,
  output rpbm_pkg::rpbm_ctl_t ctl
);

  import rpbm_pkg::*;

  localparam logic [2:0] ST_WIPE     = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_CHECK    = 3'd2;
  localparam logic [2:0] ST_DISPATCH = 3'd3;
  localparam logic [2:0] ST_LD_REQ   = 3'd4;
  localparam logic [2:0] ST_LD_CAP   = 3'd5;
  localparam logic [2:0] ST_STORE    = 3'd6;
  localparam logic [2:0] ST_RESULT   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WIPE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ctl           = '0;
    s_axis_tready = 1'b0;
    case (state)
      ST_WIPE: begin
        ctl.wipe = 1'b1;
        if (sts.wipe_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          ctl.take   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        ctl.chk    = 1'b1;
        state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        ctl.cnt_clr = 1'b1;
        state_next  = ST_RESULT;
        case (sts.cmd)
          CMD_LOAD: begin
            if (sts.allowed) begin
              state_next = ST_LD_REQ;
            end
          end
          CMD_STORE: begin
            if (sts.allowed) begin
              state_next = ST_STORE;
            end
          end
          CMD_MAP, CMD_UNMAP, CMD_CLEAR: begin
            ctl.tbl_upd = 1'b1;
          end
          default: begin
          end
        endcase
      end
      ST_LD_REQ: begin
        state_next = ST_LD_CAP;
      end
      ST_LD_CAP: begin
        ctl.rd_cap = 1'b1;
        if (sts.last_byte) begin
          state_next = ST_RESULT;
        end else begin
          ctl.cnt_inc = 1'b1;
          state_next  = ST_LD_REQ;
        end
      end
      ST_STORE: begin
        ctl.mem_we = 1'b1;
        if (sts.last_byte) begin
          state_next = ST_RESULT;
        end else begin
          ctl.cnt_inc = 1'b1;
        end
      end
      ST_RESULT: begin
        if (sts.res_free) begin
          ctl.res_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/rpbm_datapath.sv -----
module rpbm_datapath #(
  parameter int MEM_BYTES   = rpbm_pkg::RPBM_MEM_BYTES,
  parameter int MAX_REGIONS = rpbm_pkg::RPBM_MAX_REGIONS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rpbm_pkg::rpbm_ctl_t              ctl,
  output rpbm_pkg::rpbm_sts_t              sts,
  input  logic [rpbm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic [rpbm_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [rpbm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic [0:0]                       m_axis_tuser
);

  import rpbm_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [32:0]   MemLimit = 33'(MEM_BYTES);
  localparam logic [AW-1:0] WipeLast = AW'(MEM_BYTES - 1);

  // Captured input word.
  logic [CMD_W-1:0] cmd;
  logic [31:0]      addr;
  logic [1:0]       asize;
  logic [31:0]      sdata;
  logic [31:0]      rsize;
  logic [2:0]       perms;

  // Region table; regions are held as base and end, end being base plus length.
  logic [MAX_REGIONS-1:0] rvalid;
  logic [AW-1:0]          rbase [MAX_REGIONS];
  logic [AW:0]            rend  [MAX_REGIONS];
  logic [2:0]             rperm [MAX_REGIONS];

  logic [2:0]             len;
  logic [32:0]            acc_end;
  logic [32:0]            map_end;
  logic                   in_bounds;
  logic                   map_range_ok;
  logic [AW-1:0]          addr_lo;
  logic [MAX_REGIONS-1:0] hit;
  logic [MAX_REGIONS-1:0] ovl;
  logic [MAX_REGIONS-1:0] uhit;
  logic [MAX_REGIONS-1:0] first_free;
  logic                   allowed_c;
  logic                   map_ok_c;

  logic                   allowed;
  logic                   map_ok;
  logic [MAX_REGIONS-1:0] uhit_q;

  logic [1:0]    k;
  logic [AW-1:0] byte_addr;
  logic [AW-1:0] wipe_cnt;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;
  logic [7:0]    st_byte;
  logic [31:0]   acc;
  logic          ok_c;

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cmd   <= s_axis_tuser;
      addr  <= s_axis_tdata[31:0];
      asize <= s_axis_tdata[33:32];
      sdata <= s_axis_tdata[65:34];
      rsize <= s_axis_tdata[97:66];
      perms <= s_axis_tdata[100:98];
    end
  end

  always_comb begin
    case (asize)
      2'd0:    len = 3'd1;
      2'd1:    len = 3'd2;
      2'd2:    len = 3'd4;
      default: len = 3'd0;
    endcase
  end

  // The truncated address is only trusted once the access or map is known to lie
  // inside the memory.
  assign addr_lo      = addr[AW-1:0];
  assign acc_end      = {1'b0, addr} + 33'(len);
  assign in_bounds    = (len != 3'd0) && (acc_end <= MemLimit);
  assign map_end      = {1'b0, addr} + {1'b0, rsize};
  assign map_range_ok = (rsize != 32'd0) && (map_end <= MemLimit);

  always_comb begin
    for (int i = 0; i < MAX_REGIONS; i++) begin
      hit[i]  = rvalid[i] && (addr_lo >= rbase[i]) && ({1'b0, addr_lo} < rend[i]) &&
                (acc_end[AW:0] <= rend[i]) &&
                ((cmd == CMD_STORE) ? rperm[i][1] : rperm[i][0]);
      ovl[i]  = rvalid[i] && !((map_end[AW:0] <= {1'b0, rbase[i]}) ||
                               (rend[i] <= {1'b0, addr_lo}));
      uhit[i] = rvalid[i] && (addr[31:AW] == '0) && (addr_lo == rbase[i]);
    end
  end

  // Regions never overlap, so at most one entry can hold the access.
  assign allowed_c  = in_bounds && (!(|rvalid) || (|hit));
  assign map_ok_c   = map_range_ok && !(|ovl) && !(&rvalid);
  assign first_free = ~rvalid & (rvalid + 1'b1);

  always_ff @(posedge clk) begin
    if (ctl.chk) begin
      allowed <= allowed_c;
      map_ok  <= map_ok_c;
      uhit_q  <= uhit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= '0;
    end else if (ctl.tbl_upd) begin
      case (cmd)
        CMD_MAP: begin
          if (map_ok) begin
            rvalid <= rvalid | first_free;
          end
        end
        CMD_UNMAP: begin
          rvalid <= rvalid & ~uhit_q;
        end
        CMD_CLEAR: begin
          rvalid <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_REGIONS; i++) begin
      if (ctl.tbl_upd && (cmd == CMD_MAP) && map_ok && first_free[i]) begin
        rbase[i] <= addr_lo;
        rend[i]  <= map_end[AW:0];
        rperm[i] <= perms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cnt_clr) begin
      k <= 2'd0;
    end else if (ctl.cnt_inc) begin
      k <= k + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wipe_cnt <= '0;
    end else if (ctl.wipe) begin
      wipe_cnt <= wipe_cnt + 1'b1;
    end
  end

  assign byte_addr = addr_lo + AW'(k);
  assign st_byte   = 8'(sdata >> {k, 3'b000});
  assign ram_addr  = ctl.wipe ? wipe_cnt : byte_addr;
  assign ram_wdata = ctl.wipe ? 8'd0 : st_byte;

  rpbm_ram #(
    .WIDTH (8),
    .DEPTH (MEM_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.wipe | ctl.mem_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      acc <= '0;
    end else if (ctl.rd_cap) begin
      acc <= acc | (32'(ram_rdata) << {k, 3'b000});
    end
  end

  always_comb begin
    case (cmd)
      CMD_LOAD, CMD_STORE: ok_c = allowed;
      CMD_MAP:             ok_c = map_ok;
      CMD_UNMAP:           ok_c = |uhit_q;
      CMD_CLEAR:           ok_c = 1'b1;
      default:             ok_c = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctl.res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      m_axis_tdata <= ((cmd == CMD_LOAD) && allowed) ? acc : '0;
      m_axis_tuser <= ok_c;
    end
  end

  assign sts.cmd       = cmd;
  assign sts.allowed   = allowed;
  assign sts.last_byte = ({1'b0, k} == (len - 3'd1));
  assign sts.wipe_last = (wipe_cnt == WipeLast);
  assign sts.res_free  = !m_axis_tvalid || m_axis_tready;

endmodule

// ----- sv/region_protected_byte_memory_core.sv -----
// Byte-addressed little-endian memory of MEM_BYTES bytes behind a table of up to
// MAX_REGIONS protection regions. Each slave word carries one command in tuser
// (load, store, map, unmap or clear) and produces exactly one master word: tuser
// holds the success flag and tdata the loaded value, which is zero for anything
// but a successful load. Loads and stores of 1, 2 or 4 bytes may start at any
// address; they are refused when they run past the memory end or, once a region
// is mapped, when they do not sit wholly inside one region with the right
// permission. After reset the block zeroes the memory, one byte a cycle, with tready
// low. The memory is a single-port byte RAM and the controller walks an access
// through it one byte at a time: table commands and refused accesses go from
// dispatch straight to the result, a store writes its bytes in turn, and a load
// reads each byte and then captures it. The region compares all run in parallel.
// The result sits in an output register, so a new word is taken while the last
// result still waits on the master side.
module region_protected_byte_memory_core #(
  parameter int MEM_BYTES   = rpbm_pkg::RPBM_MEM_BYTES,
  parameter int MAX_REGIONS = rpbm_pkg::RPBM_MAX_REGIONS
) (
  input  logic                            clk,
  input  logic                            rst,
  // Slave side.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // From bit 0: address[31:0], access_size[33:32], store_data[65:34],
  // region_size[97:66], region_perms[100:98], zero padding[103:101].
  input  logic [rpbm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // From bit 0: command[2:0].
  input  logic [rpbm_pkg::CMD_W-1:0]      s_axis_tuser,
  // Master side.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // From bit 0: load_data[31:0].
  output logic [rpbm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // From bit 0: ok[0].
  output logic [0:0]                      m_axis_tuser
);

  import rpbm_pkg::*;

  rpbm_ctl_t ctl;
  rpbm_sts_t sts;

  // The controller sequences each word: capture, check, dispatch, byte loop,
  // and hand-off of the result to the output register.
  rpbm_controller u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .ctl           (ctl)
  );

  // The datapath holds the captured word, the region table, the byte RAM with its
  // wipe counter, and the output register.
  rpbm_datapath #(
    .MEM_BYTES   (MEM_BYTES),
    .MAX_REGIONS (MAX_REGIONS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ----- sv/rpbm_checker.sv -----
module rpbm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [rpbm_pkg::CMD_W-1:0]      s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rpbm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]                      m_axis_tuser
);

  import rpbm_pkg::*;

  logic             s_hs;
  logic             m_hs;
  logic [1:0]       outstanding;
  logic [CMD_W-1:0] last_cmd;

  assign s_hs = s_axis_tvalid && s_axis_tready;
  assign m_hs = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= 2'd0;
      last_cmd    <= CMD_LOAD;
    end else begin
      outstanding <= outstanding + 2'(s_hs) - 2'(m_hs);
      if (s_hs) begin
        last_cmd <= s_axis_tuser;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("refused result carries data");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    m_hs |-> outstanding != 2'd0)
    else $error("result without an accepted word");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> outstanding <= 2'd1)
    else $error("ready while a word is still being worked on");

  a_nonload_zero: assert property (@(posedge clk) disable iff (rst)
    m_hs && outstanding == 2'd1 && last_cmd != CMD_LOAD |-> m_axis_tdata == '0)
    else $error("data returned for a command other than load");

endmodule

bind region_protected_byte_memory_core rpbm_checker u_rpbm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- verif/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rpbm_pkg::*;

  // Commands the block does not know. Each one must still produce a refused result.
  localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

  // Access size codes carried in the slave word.
  localparam logic [1:0] SZ_BYTE  = 2'd0;
  localparam logic [1:0] SZ_HALF  = 2'd1;
  localparam logic [1:0] SZ_WORD  = 2'd2;
  localparam logic [1:0] SZ_EMPTY = 2'd3;

  // Region permission bits.
  localparam logic [2:0] PERM_RD = 3'b001;
  localparam logic [2:0] PERM_WR = 3'b010;

  localparam int RANDOM_WORDS = 450;
  localparam int TAIL_WORDS   = 60;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [31:0]           addr;
    logic                  ok;
    logic [OUT_DATA_W-1:0] load_data;
  } mem_result_t;

  // The scoreboard keeps its own image of the memory and of the region table. It works out
  // the expected result when a word is accepted and compares it with what comes out.
  class region_memory_scoreboard;
    logic [7:0]  mem_image [RPBM_MEM_BYTES];
    bit          win_valid [RPBM_MAX_REGIONS];
    logic [31:0] win_base  [RPBM_MAX_REGIONS];
    logic [31:0] win_len   [RPBM_MAX_REGIONS];
    logic [2:0]  win_perm  [RPBM_MAX_REGIONS];
    mem_result_t awaited_results [$];
    int          mismatches;

    function new();
      foreach (mem_image[i]) mem_image[i] = 8'h00;
      foreach (win_valid[i]) begin
        win_valid[i] = 1'b0;
        win_base[i]  = '0;
        win_len[i]   = '0;
        win_perm[i]  = '0;
      end
      mismatches = 0;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function int window_count();
      int n;
      n = 0;
      foreach (win_valid[i]) if (win_valid[i]) n++;
      return n;
    endfunction

    function logic [31:0] pick_valid_base();
      int unsigned idx [$];
      foreach (win_valid[i]) if (win_valid[i]) idx.insert(idx.size(), i);
      if (idx.size() == 0) return $urandom_range(0, 1023);
      return win_base[idx[$urandom_range(0, idx.size() - 1)]];
    endfunction

    function bit access_permitted(logic [31:0] addr, int unsigned len, logic [2:0] need);
      longint unsigned stop;
      int hit;
      hit = -1;
      stop = {32'b0, addr} + len;
      if (len == 0 || stop > RPBM_MEM_BYTES) return 1'b0;
      if (window_count() == 0) return 1'b1;
      foreach (win_valid[i]) begin
        if (hit < 0 && win_valid[i] && addr >= win_base[i] &&
            {32'b0, addr} < {32'b0, win_base[i]} + win_len[i])
          hit = i;
      end
      if (hit < 0) return 1'b0;
      if ((win_perm[hit] & need) != need) return 1'b0;
      return stop <= {32'b0, win_base[hit]} + win_len[hit];
    endfunction

    function bit map_window(logic [31:0] base, logic [31:0] size, logic [2:0] perms);
      longint unsigned stop;
      int slot;
      slot = -1;
      stop = {32'b0, base} + size;
      if (size == 0 || stop > RPBM_MEM_BYTES) return 1'b0;
      foreach (win_valid[i]) begin
        if (win_valid[i]) begin
          if (!(stop <= win_base[i] || {32'b0, win_base[i]} + win_len[i] <= base))
            return 1'b0;
        end else if (slot < 0) begin
          slot = i;
        end
      end
      if (slot < 0) return 1'b0;
      win_valid[slot] = 1'b1;
      win_base[slot]  = base;
      win_len[slot]   = size;
      win_perm[slot]  = perms;
      return 1'b1;
    endfunction

    function mem_result_t predict_command(logic [CMD_W-1:0] cmd, logic [31:0] addr,
                                          logic [1:0] size, logic [31:0] sdata,
                                          logic [31:0] rsize, logic [2:0] perms);
      mem_result_t res;
      int unsigned len;
      res = '0;
      res.cmd  = cmd;
      res.addr = addr;
      case (size)
        SZ_BYTE: len = 1;
        SZ_HALF: len = 2;
        SZ_WORD: len = 4;
        default: len = 0;
      endcase
      case (cmd)
        CMD_LOAD: begin
          if (access_permitted(addr, len, PERM_RD)) begin
            for (int k = 0; k < len; k++) res.load_data[8*k +: 8] = mem_image[int'(addr) + k];
            res.ok = 1'b1;
          end
        end
        CMD_STORE: begin
          if (access_permitted(addr, len, PERM_WR)) begin
            for (int k = 0; k < len; k++) mem_image[int'(addr) + k] = sdata[8*k +: 8];
            res.ok = 1'b1;
          end
        end
        CMD_MAP: res.ok = map_window(addr, rsize, perms);
        CMD_UNMAP: begin
          foreach (win_valid[i]) begin
            if (win_valid[i] && win_base[i] == addr) begin
              win_valid[i] = 1'b0;
              res.ok = 1'b1;
            end
          end
        end
        CMD_CLEAR: begin
          foreach (win_valid[i]) win_valid[i] = 1'b0;
          res.ok = 1'b1;
        end
        default: res.ok = 1'b0;
      endcase
      return res;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [31:0] addr, logic [1:0] size,
                               logic [31:0] sdata, logic [31:0] rsize, logic [2:0] perms);
      awaited_results.insert(awaited_results.size(),
                             predict_command(cmd, addr, size, sdata, rsize, perms));
    endfunction

    task report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(input logic ok, input logic [OUT_DATA_W-1:0] data);
      mem_result_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing awaited, ok %0b data %08h", ok, data));
        return;
      end
      want = awaited_results.pop_front();
      if (ok !== want.ok)
        report_mismatch($sformatf("cmd %0d addr %08h: ok %0b, predicted %0b",
                                  want.cmd, want.addr, ok, want.ok));
      if (data !== want.load_data)
        report_mismatch($sformatf("cmd %0d addr %08h: load_data %08h, predicted %08h",
                                  want.cmd, want.addr, data, want.load_data));
    endtask

    task report_leftovers();
      mem_result_t want;
      while (awaited_results.size() != 0) begin
        want = awaited_results.pop_front();
        report_mismatch($sformatf("no result came for cmd %0d addr %08h", want.cmd, want.addr));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [CMD_W-1:0]      s_axis_tuser  = CMD_LOAD;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;

  region_memory_scoreboard sb = new();

  // Idling is switched off in stretches and for the whole of the final part of the run.
  bit idle_on    = 1'b1;
  int words_sent = 0;

  region_protected_byte_memory_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Offers one word and holds it until the block takes it. When idling is on, a random
  // gap may come first; the valid is lowered in the step of the previous acceptance and
  // raised again only in a later one. The expectation is formed at the accepting edge.
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [31:0] addr,
                       input logic [1:0] size, input logic [31:0] sdata,
                       input logic [31:0] rsize, input logic [2:0] perms);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'b000, perms, rsize, sdata, size, addr};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_command(cmd, addr, size, sdata, rsize, perms);
    words_sent++;
  endtask

  // Holds the sender back until the block has returned every result that is owed.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Addresses cluster where the regions are placed, with a share near the memory end,
  // anywhere in memory, just around live regions, and over the whole 32-bit range.
  function automatic logic [31:0] pick_address();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 1023);
    if (r < 67) return RPBM_MEM_BYTES - $urandom_range(1, 8);
    if (r < 80) return $urandom_range(0, RPBM_MEM_BYTES - 1);
    if (r < 90) return sb.pick_valid_base() + $urandom_range(0, 70);
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_region_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 32'd0;
    if (r < 70) return $urandom_range(1, 96);
    if (r < 85) return $urandom_range(97, 4096);
    if (r < 93) return $urandom_range(1, RPBM_MEM_BYTES);
    return $urandom();
  endfunction

  function automatic logic [1:0] pick_size();
    return ($urandom_range(0, 15) == 0) ? SZ_EMPTY : 2'($urandom_range(SZ_BYTE, SZ_WORD));
  endfunction

  // A well-formed sequence: make room if the table is full or at times clear it, map a small
  // region, then run loads and stores in and just around it, and sometimes unmap it again.
  task automatic run_episode();
    logic [31:0]      base;
    int unsigned      span;
    logic [2:0]       perms;
    logic [CMD_W-1:0] cmd;
    if (sb.window_count() == RPBM_MAX_REGIONS)
      issue(CMD_UNMAP, sb.pick_valid_base(), pick_size(), $urandom(), $urandom(),
            3'($urandom_range(0, 7)));
    else if (sb.window_count() >= 5 && $urandom_range(0, 9) < 3)
      issue(CMD_CLEAR, $urandom(), pick_size(), $urandom(), $urandom(),
            3'($urandom_range(0, 7)));
    base  = $urandom_range(0, 1023);
    span  = $urandom_range(1, 64);
    perms = 3'($urandom_range(0, 7));
    issue(CMD_MAP, base, pick_size(), $urandom(), span, perms);
    repeat ($urandom_range(3, 8)) begin
      cmd = $urandom_range(0, 1) ? CMD_STORE : CMD_LOAD;
      issue(cmd, base + $urandom_range(0, span + 3) - 2, pick_size(), $urandom(), $urandom(),
            3'($urandom_range(0, 7)));
    end
    if ($urandom_range(0, 2) == 0)
      issue(CMD_UNMAP, base, pick_size(), $urandom(), $urandom(), 3'($urandom_range(0, 7)));
  endtask

  // A single command of any kind with loosely chosen fields.
  task automatic noise_command();
    int unsigned      r;
    logic [CMD_W-1:0] cmd;
    logic [31:0]      addr;
    r = $urandom_range(0, 99);
    if (r < 35)      cmd = CMD_LOAD;
    else if (r < 65) cmd = CMD_STORE;
    else if (r < 80) cmd = CMD_MAP;
    else if (r < 95) cmd = CMD_UNMAP;
    else if (r < 98) cmd = CMD_CLEAR;
    else             cmd = CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
    addr = pick_address();
    if (cmd == CMD_UNMAP && $urandom_range(0, 9) < 6) addr = sb.pick_valid_base();
    issue(cmd, addr, pick_size(), $urandom(), pick_region_size(), 3'($urandom_range(0, 7)));
  endtask

  // Receiver: the master-side ready drops in random bursts while idling is on.
  initial begin
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Every word taken on the master side is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser[0], m_axis_tdata);
  end

  // The clearing pass after reset alone takes some half a millisecond; the rest of the run
  // is well under that, so this leaves ample headroom.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int rand_first;
    int n;
    int pick;
    int w;
    bit drained_once;
    drained_once = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The memory starts cleared and no region is mapped, so every access
    // inside the memory is allowed at first.
    issue(CMD_LOAD,  32'h0000_0000, SZ_WORD,  '0, '0, '0);
    issue(CMD_STORE, 32'h0000_0000, SZ_WORD,  32'hA1B2_C3D4, '0, '0);
    issue(CMD_LOAD,  32'h0000_0003, SZ_BYTE,  '0, '0, '0);
    issue(CMD_LOAD,  32'h0000_0001, SZ_HALF,  '0, '0, '0);
    issue(CMD_STORE, RPBM_MEM_BYTES - 4, SZ_WORD, 32'hFFFF_FFFF, '0, '0);
    // A halfword at the last byte runs past the end; the last byte on its own does not.
    issue(CMD_LOAD,  RPBM_MEM_BYTES - 1, SZ_HALF, '0, '0, '0);
    issue(CMD_LOAD,  RPBM_MEM_BYTES - 1, SZ_BYTE, '0, '0, '0);
    // The empty access size, and an address at the top of the 32-bit range.
    issue(CMD_LOAD,  32'h0000_0000, SZ_EMPTY, '0, '0, '0);
    issue(CMD_STORE, 32'hFFFF_FFFF, SZ_WORD,  32'h1234_5678, '0, '0);
    // Unmapping with an empty table, then maps refused for zero size and for running past
    // the memory end.
    issue(CMD_UNMAP, 32'h0000_0000, SZ_BYTE, '0, '0, '0);
    issue(CMD_MAP,   32'h0000_0000, SZ_BYTE, '0, 32'd0, PERM_RD);
    issue(CMD_MAP,   RPBM_MEM_BYTES - 16, SZ_BYTE, '0, 32'd17, PERM_RD);
    // A read-only region, an overlapping map, and accesses inside, across the end of the
    // region, without write permission and outside any region.
    issue(CMD_MAP,   32'h0000_0100, SZ_BYTE, '0, 32'h40, PERM_RD);
    issue(CMD_MAP,   32'h0000_0120, SZ_BYTE, '0, 32'h40, PERM_RD | PERM_WR);
    issue(CMD_LOAD,  32'h0000_013C, SZ_WORD, '0, '0, '0);
    issue(CMD_LOAD,  32'h0000_013E, SZ_WORD, '0, '0, '0);
    issue(CMD_STORE, 32'h0000_0100, SZ_BYTE, 32'h0000_00AA, '0, '0);
    issue(CMD_LOAD,  32'h0000_0000, SZ_BYTE, '0, '0, '0);
    // Fill the table with every non-zero permission combination; one more map finds it full.
    for (int i = 0; i < RPBM_MAX_REGIONS - 1; i++)
      issue(CMD_MAP, 32'h400 + 16 * i, SZ_BYTE, '0, 32'd16, 3'(i + 1));
    issue(CMD_MAP,   32'h0000_0800, SZ_BYTE, '0, 32'd8, PERM_RD | PERM_WR);
    // The second of those regions may be written but not read.
    issue(CMD_STORE, 32'h0000_041E, SZ_HALF, 32'hBEEF_5A5A, '0, '0);
    issue(CMD_LOAD,  32'h0000_041E, SZ_HALF, '0, '0, '0);
    issue(CMD_UNMAP, 32'h0000_0100, SZ_BYTE, '0, '0, '0);
    issue(CMD_CLEAR, 32'h0000_0000, SZ_BYTE, '0, '0, '0);
    for (int c = CMD_RSVD_FIRST; c <= CMD_RSVD_LAST; c++)
      issue(3'(c), $urandom(), pick_size(), $urandom(), $urandom(), 3'($urandom_range(0, 7)));

    // Random part: mostly well-formed map-then-access sequences, the rest loose commands.
    rand_first = words_sent;
    while (words_sent - rand_first < RANDOM_WORDS) begin
      n = words_sent - rand_first;
      idle_on = (n < RANDOM_WORDS - TAIL_WORDS) && ((n / 70) % 3 != 2);
      if (!drained_once && n >= 150) begin
        wait_for_results();
        drained_once = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55)
        run_episode();
      else if (pick < 94)
        noise_command();
      else if (pick < 97)
        issue(CMD_CLEAR, $urandom(), pick_size(), $urandom(), $urandom(),
              3'($urandom_range(0, 7)));
      else
        issue(CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST)), $urandom(), pick_size(),
              $urandom(), $urandom(), 3'($urandom_range(0, 7)));
    end

    // Let the last results drain, then give the block a little longer in case it sends
    // anything it should not.
    s_axis_tvalid <= 1'b0;
    for (w = 0; w < 4000 && sb.pending() != 0; w++) @(posedge clk);
    repeat (40) @(posedge clk);
    sb.report_leftovers();
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/rpbm_pkg.sv
sv/rpbm_ram.sv
sv/rpbm_controller.sv
sv/rpbm_datapath.sv
sv/region_protected_byte_memory_core.sv
sv/rpbm_checker.sv
verif/testbench.sv
